### sv/ate_pkg.sv
// Shared types, codes and helper functions of the ANSI text console engine.
// Used by the controller, the datapath and the top level.
package ate_pkg;

    // Datapath operations issued by the controller.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_LATCH = 3'd1;
    localparam logic [OP_W-1:0] OP_PREP  = 3'd2;
    localparam logic [OP_W-1:0] OP_EXEC  = 3'd3;
    localparam logic [OP_W-1:0] OP_STEP  = 3'd4;
    localparam logic [OP_W-1:0] OP_OUT   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } ate_cmd_t;

    typedef struct packed {
        logic busy;      // A memory walk, a cell write or an SGR run is pending.
        logic out_free;  // The output register can take a new result.
    } ate_status_t;

    // Configuration register indexes.
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [5:0] ROWS_RESET = 6'd25;

    // Byte codes.
    localparam logic [7:0] B_HOME   = 8'h01;
    localparam logic [7:0] B_EOL    = 8'h05;
    localparam logic [7:0] B_STEP   = 8'h06;
    localparam logic [7:0] B_BS     = 8'h08;
    localparam logic [7:0] B_TAB    = 8'h09;
    localparam logic [7:0] B_LF     = 8'h0a;
    localparam logic [7:0] B_FF     = 8'h0c;
    localparam logic [7:0] B_CR     = 8'h0d;
    localparam logic [7:0] B_ESC    = 8'h1b;
    localparam logic [7:0] B_SPACE  = 8'h20;
    localparam logic [7:0] B_SEMI   = 8'h3b;
    localparam logic [7:0] B_ZERO   = 8'h30;
    localparam logic [7:0] B_NINE   = 8'h39;
    localparam logic [7:0] B_LBRACK = 8'h5b;
    localparam logic [7:0] B_UP_A   = 8'h41;
    localparam logic [7:0] B_UP_Z   = 8'h5a;
    localparam logic [7:0] B_LO_A   = 8'h61;
    localparam logic [7:0] B_LO_Z   = 8'h7a;
    localparam logic [7:0] B_CUP    = 8'h48;  // H
    localparam logic [7:0] B_HVP    = 8'h66;  // f
    localparam logic [7:0] B_SGR    = 8'h6d;  // m
    localparam logic [7:0] B_ECH    = 8'h58;  // X
    localparam logic [7:0] B_EL     = 8'h4b;  // K
    localparam logic [7:0] B_ED     = 8'h4a;  // J
    localparam logic [7:0] CH_MICRO = 8'hb5;
    localparam logic [7:0] CH_MU    = 8'he6;

    localparam logic [15:0] ATTR_RESET = 16'h0007;
    localparam logic [15:0] ATTR_BOLD  = 16'h0808;
    localparam logic [15:0] ATTR_BLINK = 16'h8080;

    // ANSI color number to text-mode color bits.
    function automatic logic [2:0] sgr_colour(input logic [2:0] c);
        logic [2:0] r;
        begin
            unique case (c)
                3'd0: r = 3'd0;
                3'd1: r = 3'd4;
                3'd2: r = 3'd2;
                3'd3: r = 3'd6;
                3'd4: r = 3'd1;
                3'd5: r = 3'd5;
                3'd6: r = 3'd3;
                default: r = 3'd7;
            endcase
            return r;
        end
    endfunction

    // One SGR argument applied to the current attribute.
    function automatic logic [15:0] sgr_apply(input logic [15:0] t, input logic [15:0] a);
        logic [15:0] r;
        begin
            r = t;
            if (a == 16'd0)
                r = ATTR_RESET;
            else if (a == 16'd1)
                r = t | ATTR_BOLD;
            else if (a == 16'd22)
                r = t & ~ATTR_BOLD;
            else if (a == 16'd5)
                r = t | ATTR_BLINK;
            else if (a >= 16'd30 && a <= 16'd37)
                r = (t & 16'h00f0) | {13'd0, sgr_colour(3'(a - 16'd30))}
                    | ((t >> 8) & 16'h0008);
            else if (a >= 16'd40 && a <= 16'd47)
                r = (t & 16'h000f) | {9'd0, sgr_colour(3'(a - 16'd40)), 4'd0}
                    | ((t >> 8) & 16'h0080);
            return r;
        end
    endfunction

endpackage

### sv/ansi_text_console_engine.sv
// Text terminal with an ANSI escape parser: every input transfer puts one byte
// to the screen or reads one screen cell, and every input transfer gives one result
// transfer. Input: tuser holds the command, tdata the byte and the cell index.
// Output: tdata holds the read cell, the cursor position and the escape flag.
// Configuration: cfg_we writes cfg_wdata to columns (index 0) or rows (index 1).
// A printable byte adds a cell write to the steps that a read or a byte that
// touches no memory goes through on its way to the output register. A line feed
// that scrolls walks the cell memory once, an SGR applies its arguments one by
// one, and erases blank one cell at a time; one memory write port sets that
// pace.
// The next item is taken once the previous result sits in the output register,
// which waits there while the receiver stalls; a second result waits for it.
// After reset the cell memory is blanked by a walk over all MAX_COLS*MAX_ROWS cells, and
// no input transfer is taken meanwhile; configuration writes are taken as ever.
module ansi_text_console_engine
    import ate_pkg::*;
#(
    parameter int MAX_COLS   = 128,
    parameter int MAX_ROWS   = 32,
    parameter int ESC_PARAMS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // byte_in[7:0], cell_addr[19:8]
    input  logic [0:0]  s_axis_tuser,   // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // cell_char[7:0], cell_attr[15:8],
                                        // cursor_col[23:16], cursor_row[28:24],
                                        // in_escape[29]
);

    ate_cmd_t    cmd;
    ate_status_t status;
    logic [29:0] out_data;

    ate_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ate_dp #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .ESC_PARAMS (ESC_PARAMS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_axis_tuser[0]),
        .in_byte   (s_axis_tdata[7:0]),
        .in_addr   (s_axis_tdata[19:8]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {2'b00, out_data};

endmodule

### sv/ate_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ate_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/ate_ctrl.sv
// Controller of the ANSI text console engine: sequences clear, decode, memory walk
// and result delivery. Depends on ate_pkg.
module ate_ctrl
    import ate_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ate_status_t status,
    output ate_cmd_t    cmd
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                if (status.busy)
                    cmd.op = OP_STEP;
                else
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.op     = OP_EXEC;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (status.busy)
                    cmd.op = OP_STEP;
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

endmodule

### sv/ate_dp.sv
// Datapath of the ANSI text console engine: cursor, attribute, escape parser,
// cell memory walker and output register. Depends on ate_pkg and ate_ram.
module ate_dp
    import ate_pkg::*;
#(
    parameter int MAX_COLS   = 128,
    parameter int MAX_ROWS   = 32,
    parameter int ESC_PARAMS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ate_cmd_t    cmd,
    output ate_status_t status,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_cmd,
    input  logic [7:0]  in_byte,
    input  logic [11:0] in_addr,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [29:0] out_data
);

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AAW   = $clog2(CELLS);
    localparam int AW    = AAW + 1;
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int PIW   = $clog2(ESC_PARAMS);
    localparam int FW    = ((AW > 16) ? AW : 16) + 1;

    logic [7:0]     cols_reg;
    logic [5:0]     rows_reg;
    logic [CW-1:0]  cu;
    logic [RW-1:0]  ru;
    logic [AW-1:0]  lim_reg, lim_next;

    logic [CW-1:0]  col_reg, col_next;
    logic [RIW-1:0] row_reg, row_next;
    logic [15:0]    attr_reg, attr_next;
    logic           esc_reg, esc_next;
    logic [15:0]    par_reg [ESC_PARAMS];
    logic [15:0]    par_next [ESC_PARAMS];
    logic [PIW-1:0] idx_reg, idx_next;

    logic           lcmd_reg;
    logic [7:0]     lbyte_reg;
    logic [11:0]    laddr_reg;
    logic           rdok_reg, rdok_next;
    logic [AW-1:0]  rowbase_reg, rowbase_next;

    logic [AW-1:0]  ptr_reg, ptr_next;
    logic [AW-1:0]  end_reg, end_next;
    logic           copy_reg, copy_next;
    logic           fill_reg, fill_next;
    logic           cpw_reg, cpw_next;
    logic [AAW-1:0] cpwa_reg, cpwa_next;
    logic           char_reg, char_next;
    logic [AAW-1:0] chara_reg, chara_next;
    logic [15:0]    chard_reg, chard_next;
    logic           sgr_reg, sgr_next;
    logic [PIW-1:0] sgri_reg, sgri_next;

    logic           ov_reg, ov_next;
    logic [29:0]    od_reg, od_next;

    logic           ram_we, ram_re;
    logic [AAW-1:0] ram_waddr, ram_raddr;
    logic [15:0]    ram_wdata, ram_rdata;

    // Exec helpers.
    logic [RIW-1:0] row_cl;
    logic [CW-1:0]  col_cl;
    logic [AW-1:0]  cur_addr, row_end;
    logic           set_fill;
    logic [AW-1:0]  fill_from;
    logic [FW-1:0]  fill_to;
    logic [CW:0]    col_w;
    logic [RW-1:0]  row_inc;
    logic           last_row;
    logic [15:0]    p0, p1, pv, psel;
    logic [PIW-1:0] psel_idx;
    logic           is_letter;

    always_comb
    begin
        if (cols_reg == 8'd0)
            cu = CW'(1);
        else if (int'(cols_reg) > MAX_COLS)
            cu = CW'(MAX_COLS);
        else
            cu = CW'(cols_reg);
        if (rows_reg == 6'd0)
            ru = RW'(1);
        else if (int'(rows_reg) > MAX_ROWS)
            ru = RW'(MAX_ROWS);
        else
            ru = RW'(rows_reg);
    end

    assign lim_next = AW'(cu) * AW'(ru);

    assign row_cl = (RW'(row_reg) >= ru) ? RIW'(ru - RW'(1)) : row_reg;
    assign col_cl = (col_reg > cu) ? cu : col_reg;
    assign rowbase_next = AW'(row_cl) * AW'(cu);

    assign cur_addr = rowbase_reg + AW'(col_reg);
    assign row_end  = rowbase_reg + AW'(cu);
    assign row_inc  = RW'(row_reg) + RW'(1);
    assign last_row = (row_inc >= ru);
    assign p0 = par_reg[0];
    assign p1 = par_reg[1];
    // A shared read port into the argument registers, beside the fixed reads of the first two.
    assign psel_idx = sgr_reg ? sgri_reg : idx_reg;
    assign psel     = par_reg[psel_idx];
    assign is_letter = (lbyte_reg >= B_UP_A && lbyte_reg <= B_UP_Z)
                    || (lbyte_reg >= B_LO_A && lbyte_reg <= B_LO_Z);

    assign status.busy     = copy_reg | fill_reg | char_reg | sgr_reg;
    assign status.out_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        attr_next  = attr_reg;
        esc_next   = esc_reg;
        par_next   = par_reg;
        idx_next   = idx_reg;
        rdok_next  = rdok_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        copy_next  = copy_reg;
        fill_next  = fill_reg;
        cpw_next   = cpw_reg;
        cpwa_next  = cpwa_reg;
        char_next  = char_reg;
        chara_next = chara_reg;
        chard_next = chard_reg;
        sgr_next   = sgr_reg;
        sgri_next  = sgri_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        ram_we     = 1'b0;
        ram_waddr  = ptr_reg[AAW-1:0];
        ram_wdata  = {attr_reg[7:0], B_SPACE};
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg[AAW-1:0];
        set_fill   = 1'b0;
        fill_from  = cur_addr;
        fill_to    = FW'(row_end);
        col_w      = '0;
        pv         = 16'd0;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (cmd.op)
            OP_PREP:
            begin
                row_next = row_cl;
                col_next = col_cl;
            end
            OP_EXEC:
            begin
                if (lcmd_reg)
                begin
                    rdok_next = (int'(laddr_reg) < CELLS);
                    ram_re    = 1'b1;
                    ram_raddr = AAW'(laddr_reg);
                end
                else if (esc_reg)
                begin
                    if (lbyte_reg == B_LBRACK)
                    begin
                        for (int i = 0; i < ESC_PARAMS; i++)
                            par_next[i] = 16'd0;
                        idx_next = '0;
                    end
                    else if (lbyte_reg == B_SEMI)
                    begin
                        if (int'(idx_reg) + 1 < ESC_PARAMS)
                        begin
                            idx_next = PIW'(idx_reg + 1'b1);
                            par_next[PIW'(idx_reg + 1'b1)] = 16'd0;
                        end
                    end
                    else if (lbyte_reg >= B_ZERO && lbyte_reg <= B_NINE)
                    begin
                        par_next[idx_reg] = (psel << 3) + (psel << 1)
                                          + {12'd0, lbyte_reg[3:0]};
                    end
                    else if (is_letter)
                    begin
                        esc_next = 1'b0;
                        if (lbyte_reg == B_CUP || lbyte_reg == B_HVP)
                        begin
                            pv = (p1 == 16'd0) ? 16'd0 : p1 - 16'd1;
                            if (pv >= 16'(cu))
                                col_next = CW'(cu - CW'(1));
                            else
                                col_next = CW'(pv);
                            pv = (p0 == 16'd0) ? 16'd0 : p0 - 16'd1;
                            if (pv >= 16'(ru))
                                row_next = RIW'(ru - RW'(1));
                            else
                                row_next = RIW'(pv);
                        end
                        else if (lbyte_reg == B_SGR)
                        begin
                            sgr_next  = 1'b1;
                            sgri_next = '0;
                        end
                        else if (lbyte_reg == B_ECH)
                        begin
                            set_fill = 1'b1;
                            fill_to  = FW'(cur_addr) + FW'(p0);
                        end
                        else if (lbyte_reg == B_EL)
                        begin
                            set_fill = 1'b1;
                            if (p0 == 16'd1)
                            begin
                                fill_from = rowbase_reg;
                                fill_to   = FW'(cur_addr);
                            end
                            else if (p0 == 16'd2)
                            begin
                                fill_from = rowbase_reg;
                            end
                        end
                        else if (lbyte_reg == B_ED)
                        begin
                            set_fill = 1'b1;
                            if (p0 == 16'd1)
                            begin
                                fill_from = '0;
                                fill_to   = FW'(rowbase_reg);
                            end
                            else if (p0 == 16'd2)
                            begin
                                fill_from = '0;
                                fill_to   = FW'(lim_reg);
                            end
                            else
                            begin
                                fill_from = rowbase_reg;
                                fill_to   = FW'(lim_reg);
                            end
                        end
                    end
                end
                else
                begin
                    if (lbyte_reg == B_LF || lbyte_reg == B_FF)
                    begin
                        col_next = '0;
                        if (last_row)
                        begin
                            copy_next = 1'b1;
                            cpw_next  = 1'b0;
                            ptr_next  = AW'(cu);
                            end_next  = lim_reg;
                        end
                        else
                            row_next = RIW'(row_inc);
                    end
                    else if (lbyte_reg == B_CR)
                        col_next = '0;
                    else if (lbyte_reg == B_TAB)
                    begin
                        col_w = ({1'b0, col_reg} & ~(CW+1)'(7)) + (CW+1)'(8);
                        col_next = (col_w > (CW+1)'(cu)) ? cu : CW'(col_w);
                    end
                    else if (lbyte_reg == B_ESC)
                        esc_next = 1'b1;
                    else if (lbyte_reg == B_STEP)
                    begin
                        row_next = last_row ? RIW'(ru - RW'(1)) : RIW'(row_inc);
                        col_w = {1'b0, col_reg} + (CW+1)'(2);
                        col_next = (col_w >= (CW+1)'(cu)) ? CW'(cu - CW'(1)) : CW'(col_w);
                    end
                    else if (lbyte_reg == B_HOME)
                    begin
                        col_next = '0;
                        row_next = '0;
                    end
                    else if (lbyte_reg == B_EOL)
                        set_fill = 1'b1;
                    else if (lbyte_reg == B_BS)
                    begin
                        if (col_reg != '0)
                            col_next = CW'(col_reg - CW'(1));
                    end
                    else if (lbyte_reg >= B_SPACE)
                    begin
                        char_next  = 1'b1;
                        chard_next = {attr_reg[7:0],
                                      (lbyte_reg == CH_MICRO) ? CH_MU : lbyte_reg};
                        if (col_reg >= cu)
                        begin
                            // Pending wrap: the character lands at column 0 below.
                            col_next = CW'(1);
                            if (last_row)
                            begin
                                copy_next  = 1'b1;
                                cpw_next   = 1'b0;
                                ptr_next   = AW'(cu);
                                end_next   = lim_reg;
                                chara_next = AAW'(rowbase_reg);
                            end
                            else
                            begin
                                row_next   = RIW'(row_inc);
                                chara_next = AAW'(row_end);
                            end
                        end
                        else
                        begin
                            col_next   = CW'(col_reg + CW'(1));
                            chara_next = AAW'(cur_addr);
                        end
                    end
                end
                if (set_fill)
                begin
                    fill_next = 1'b1;
                    ptr_next  = fill_from;
                    end_next  = (fill_to > FW'(lim_reg)) ? lim_reg : AW'(fill_to);
                end
            end
            OP_STEP:
            begin
                if (copy_reg)
                begin
                    // Scroll: read one cell ahead, write it a row higher on the next step.
                    if (cpw_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cpwa_reg;
                        ram_wdata = ram_rdata;
                    end
                    if (ptr_reg < end_reg)
                    begin
                        ram_re    = 1'b1;
                        cpw_next  = 1'b1;
                        cpwa_next = AAW'(ptr_reg - AW'(cu));
                        ptr_next  = ptr_reg + AW'(1);
                    end
                    else
                    begin
                        cpw_next = 1'b0;
                        if (!cpw_reg)
                        begin
                            copy_next = 1'b0;
                            fill_next = 1'b1;
                            ptr_next  = lim_reg - AW'(cu);
                            end_next  = lim_reg;
                        end
                    end
                end
                else if (fill_reg)
                begin
                    if (ptr_reg < end_reg)
                    begin
                        ram_we   = 1'b1;
                        ptr_next = ptr_reg + AW'(1);
                    end
                    else
                        fill_next = 1'b0;
                end
                else if (char_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = chara_reg;
                    ram_wdata = chard_reg;
                    char_next = 1'b0;
                end
                else if (sgr_reg)
                begin
                    attr_next = sgr_apply(attr_reg, psel);
                    if (sgri_reg == idx_reg)
                        sgr_next = 1'b0;
                    else
                        sgri_next = PIW'(sgri_reg + 1'b1);
                end
            end
            OP_OUT:
            begin
                ov_next = 1'b1;
                od_next = {esc_reg, 5'(row_reg), 8'(col_reg),
                           (lcmd_reg && rdok_reg) ? ram_rdata : 16'd0};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
            col_reg  <= '0;
            row_reg  <= '0;
            attr_reg <= ATTR_RESET;
            esc_reg  <= 1'b0;
            for (int i = 0; i < ESC_PARAMS; i++)
                par_reg[i] <= 16'd0;
            idx_reg  <= '0;
            // The cell memory is blanked after reset by a fill walk over all cells.
            ptr_reg  <= '0;
            end_reg  <= AW'(CELLS);
            copy_reg <= 1'b0;
            fill_reg <= 1'b1;
            cpw_reg  <= 1'b0;
            char_reg <= 1'b0;
            sgr_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_COLS: cols_reg <= cfg_wdata;
                    REG_ROWS: rows_reg <= cfg_wdata[5:0];
                    default:  cols_reg <= cols_reg;
                endcase
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            attr_reg <= attr_next;
            esc_reg  <= esc_next;
            par_reg  <= par_next;
            idx_reg  <= idx_next;
            ptr_reg  <= ptr_next;
            end_reg  <= end_next;
            copy_reg <= copy_next;
            fill_reg <= fill_next;
            cpw_reg  <= cpw_next;
            char_reg <= char_next;
            sgr_reg  <= sgr_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg    <= lim_next;
        rdok_reg   <= rdok_next;
        cpwa_reg   <= cpwa_next;
        chara_reg  <= chara_next;
        chard_reg  <= chard_next;
        sgri_reg   <= sgri_next;
        od_reg     <= od_next;
        if (cmd.op == OP_LATCH)
        begin
            lcmd_reg  <= in_cmd;
            lbyte_reg <= in_byte;
            laddr_reg <= in_addr;
        end
        if (cmd.op == OP_PREP)
            rowbase_reg <= rowbase_next;
    end

    ate_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### sim/ansi_text_console_engine_test.sv
// Testbench of the ANSI text console engine: puts bytes and reads cells through
// the input stream, predicts every result and compares it. Depends on ate_pkg and ansi_text_console_engine.
`timescale 1ns / 1ps

module ansi_text_console_engine_test;
    import ate_pkg::*;

    localparam int NCOLS = 128;
    localparam int NROWS = 32;
    localparam int NCELL = NCOLS * NROWS;
    localparam int NARGS = 5;
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic       esc;
        logic [4:0] row;
        logic [7:0] col;
        logic [7:0] attr;
        logic [7:0] chr;
    } term_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 24'd0;
    logic [0:0]  s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    ansi_text_console_engine uut (.*);

    // Predicted terminal state.
    logic [15:0] scr [NCELL];
    int unsigned pcol, prow, pcols, prows, pidx;
    logic [15:0] pattr;
    logic [15:0] pargs [NARGS];
    logic        pesc;
    term_view_t  view_q [$];
    int          errors = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    logic        recv_on = 1'b0;

    initial forever #5 clk = ~clk;

    initial
    begin
        #400ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned ucols();
        return pcols == 0 ? 1 : (pcols > NCOLS ? NCOLS : pcols);
    endfunction

    function automatic int unsigned urows();
        return prows == 0 ? 1 : (prows > NROWS ? NROWS : prows);
    endfunction

    task automatic blank_cells(input int unsigned from, input int unsigned upto);
        int unsigned lim;
        lim = ucols() * urows();
        if (upto > lim) upto = lim;
        for (int unsigned i = from; i < upto; i++) scr[i] = {pattr[7:0], B_SPACE};
    endtask

    task automatic line_down();
        int unsigned c, r;
        c = ucols();
        r = urows();
        prow++;
        if (prow >= r)
        begin
            for (int unsigned i = c; i < c * r; i++) scr[i - c] = scr[i];
            blank_cells((r - 1) * c, r * c);
            prow = r - 1;
        end
    endtask

    function automatic logic [2:0] colour_map(input int unsigned n);
        logic [2:0] m [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
        return m[n];
    endfunction

    task automatic apply_rendition(input int unsigned a);
        logic [15:0] t;
        t = pattr;
        if (a == 0) t = 16'h0007;
        else if (a == 1) t = t | 16'h0808;
        else if (a == 22) t = t & ~16'h0808;
        else if (a == 5) t = t | 16'h8080;
        else if (a >= 30 && a <= 37)
            t = (t & 16'h00f0) | colour_map(a - 30) | ((t >> 8) & 16'h0008);
        else if (a >= 40 && a <= 47)
            t = (t & 16'h000f) | (16'(colour_map(a - 40)) << 4) | ((t >> 8) & 16'h0080);
        pattr = t;
    endtask

    task automatic escape_put(input logic [7:0] b);
        int unsigned c, r, p0, p1, base;
        c = ucols();
        r = urows();
        if (b == B_LBRACK)
        begin
            foreach (pargs[i]) pargs[i] = 16'd0;
            pidx = 0;
        end
        else if (b == B_SEMI)
        begin
            if (pidx + 1 < NARGS)
            begin
                pidx++;
                pargs[pidx] = 16'd0;
            end
        end
        else if (b >= B_ZERO && b <= B_NINE)
            pargs[pidx] = 16'(pargs[pidx] * 10 + (b - B_ZERO));
        else if ((b >= B_UP_A && b <= B_UP_Z) || (b >= B_LO_A && b <= B_LO_Z))
        begin
            pesc = 1'b0;
            p0 = pargs[0];
            p1 = pargs[1];
            base = prow * c;
            case (b)
                B_CUP, B_HVP:
                begin
                    pcol = p1 ? p1 - 1 : 0;
                    prow = p0 ? p0 - 1 : 0;
                    if (pcol >= c) pcol = c - 1;
                    if (prow >= r) prow = r - 1;
                end
                B_SGR: for (int unsigned i = 0; i <= pidx; i++) apply_rendition(pargs[i]);
                B_ECH: blank_cells(base + pcol, base + pcol + p0);
                B_EL:
                    if (p0 == 1) blank_cells(base, base + pcol);
                    else if (p0 == 2) blank_cells(base, base + c);
                    else blank_cells(base + pcol, base + c);
                B_ED:
                    if (p0 == 1) blank_cells(0, base);
                    else if (p0 == 2) blank_cells(0, r * c);
                    else blank_cells(base, r * c);
                default: ;
            endcase
        end
    endtask

    task automatic predict_step(input logic cmd, input logic [7:0] b, input logic [11:0] addr);
        int unsigned c;
        term_view_t v;
        c = ucols();
        if (prow >= urows()) prow = urows() - 1;
        if (pcol > c) pcol = c;
        v = '0;
        if (cmd == CMD_PUT)
        begin
            if (pesc) escape_put(b);
            else case (b)
                B_LF, B_FF:
                begin
                    pcol = 0;
                    line_down();
                end
                B_CR: pcol = 0;
                B_TAB:
                begin
                    pcol = (pcol & ~32'd7) + 8;
                    if (pcol > c) pcol = c;
                end
                B_ESC: pesc = 1'b1;
                B_STEP:
                begin
                    prow++;
                    pcol += 2;
                    if (prow >= urows()) prow = urows() - 1;
                    if (pcol >= c) pcol = c - 1;
                end
                B_HOME:
                begin
                    pcol = 0;
                    prow = 0;
                end
                B_EOL: blank_cells(prow * c + pcol, prow * c + c);
                B_BS: if (pcol != 0) pcol--;
                default:
                    if (b >= B_SPACE)
                    begin
                        if (pcol >= c)
                        begin
                            pcol = 0;
                            line_down();
                        end
                        scr[prow * c + pcol] = {pattr[7:0], (b == CH_MICRO) ? CH_MU : b};
                        pcol++;
                    end
            endcase
        end
        else if (addr < NCELL)
        begin
            v.chr = scr[addr][7:0];
            v.attr = scr[addr][15:8];
        end
        v.col = 8'(pcol);
        v.row = 5'(prow);
        v.esc = pesc;
        view_q.push_back(v);
    endtask

    task automatic send_item(input logic cmd, input logic [7:0] b, input logic [11:0] addr);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk);
        predict_step(cmd, b, addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {addr, b};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        s_axis_tvalid <= 1'b0;
        // The block takes no new transfer until the previous result is in its output register anyway.
        @(posedge clk);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) send_item(CMD_PUT, s[i], 12'd0);
    endtask

    task automatic read_cell(input int unsigned a);
        send_item(CMD_READ, 8'd0, 12'(a));
    endtask

    // Waits for every expected result, then lets the block settle.
    task automatic drain();
        while (view_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        if (idx == REG_COLS) pcols = val;
        else prows = val[5:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // The receiver stalls at random as the current phase asks.
    always @(posedge clk)
    begin
        if (recv_stall > 0 && $urandom_range(99) < recv_stall) m_axis_tready <= 1'b0;
        else m_axis_tready <= recv_on;
    end

    always @(posedge clk)
    begin
        term_view_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[29:0];
            if (view_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = view_q.pop_front();
                if (got.chr !== want.chr)
                    begin $display("%0t: cell_char exp %h got %h", $time, want.chr, got.chr);
                    errors++; end
                if (got.attr !== want.attr)
                    begin $display("%0t: cell_attr exp %h got %h", $time, want.attr, got.attr);
                    errors++; end
                if (got.col !== want.col)
                    begin $display("%0t: cursor_col exp %0d got %0d", $time, want.col, got.col);
                    errors++; end
                if (got.row !== want.row)
                    begin $display("%0t: cursor_row exp %0d got %0d", $time, want.row, got.row);
                    errors++; end
                if (got.esc !== want.esc)
                    begin $display("%0t: in_escape exp %0d got %0d", $time, want.esc, got.esc);
                    errors++; end
            end
        end
    end

    task automatic test_controls();
        put_str("Ab");
        send_item(CMD_PUT, CH_MICRO, 0);
        send_item(CMD_PUT, 8'hff, 0);
        send_item(CMD_PUT, B_TAB, 0);
        send_item(CMD_PUT, B_BS, 0);
        send_item(CMD_PUT, B_STEP, 0);
        send_item(CMD_PUT, B_CR, 0);
        send_item(CMD_PUT, B_EOL, 0);
        send_item(CMD_PUT, B_HOME, 0);
        send_item(CMD_PUT, 8'h00, 0);
        send_item(CMD_PUT, B_LF, 0);
        send_item(CMD_PUT, B_FF, 0);
        read_cell(2);
        read_cell(3);
        read_cell(4095);
    endtask

    task automatic test_escapes();
        put_str("\033[1;31;44;5;22;7mZ\033[3;4HQ\033[9;9f\033[2X\033[1K\033[K\033[2K");
        put_str("\033[1J\033[J\033[2J\033[0m\033[1;2;3;4;5;6;99999q\033\033?x");
        read_cell(0);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] pool [12] = '{B_LF, B_CR, B_TAB, B_BS, B_STEP, B_HOME, B_EOL, B_FF,
                                   B_ESC, B_LBRACK, B_SEMI, 8'h31};
        logic [7:0] fin [8] = '{B_CUP, B_HVP, B_SGR, B_ECH, B_EL, B_ED, 8'h41, 8'h7a};
        int unsigned k;
        k = $urandom_range(99);
        if (k < 45) return 8'($urandom_range(8'h20, 8'hff));
        if (k < 65) return pool[$urandom_range(11)];
        if (k < 80) return 8'($urandom_range(B_ZERO, B_NINE));
        if (k < 90) return fin[$urandom_range(7)];
        return 8'($urandom);
    endfunction

    task automatic run_random(input int n);
        int unsigned lim;
        for (int i = 0; i < n; i++)
        begin
            lim = ucols() * urows();
            if ($urandom_range(99) < 25)
                read_cell($urandom_range(99) < 90 ? $urandom_range(lim + 4) : $urandom_range(4095));
            else if ($urandom_range(99) < 15)
            begin
                // A CSI sequence with random arguments and a random final byte.
                send_item(CMD_PUT, B_ESC, 0);
                send_item(CMD_PUT, B_LBRACK, 0);
                put_str($sformatf("%0d;%0d", $urandom_range(50), $urandom_range(140)));
                send_item(CMD_PUT, pick_byte(), 0);
            end
            else
                send_item(CMD_PUT, pick_byte(), 0);
        end
    endtask

    task automatic test_phase(input int si, input int rs, input logic [7:0] c,
                              input logic [5:0] r, input int n);
        write_reg(REG_COLS, c);
        write_reg(REG_ROWS, r);
        send_idle = si;
        recv_stall = rs;
        run_random(n);
    endtask

    initial
    begin
        for (int i = 0; i < NCELL; i++) scr[i] = 16'h0720;
        foreach (pargs[i]) pargs[i] = 16'd0;
        pcol = 0; prow = 0; pidx = 0; pattr = 16'h0007; pesc = 1'b0;
        pcols = COLS_RESET; prows = ROWS_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        recv_on <= 1'b1;
        test_controls();
        test_escapes();
        test_phase(0, 0, 8'd12, 6'd4, 140);
        test_phase(72, 0, 8'd1, 6'd1, 115);
        test_phase(0, 72, 8'd128, 6'd32, 140);
        test_phase(35, 35, 8'd0, 6'd0, 85);
        test_phase(0, 0, 8'd255, 6'd63, 85);
        test_phase(35, 35, 8'd9, 6'd3, 170);
        test_phase(72, 0, 8'd5, 6'd2, 140);
        test_phase(0, 72, 8'd80, 6'd25, 115);
        drain();
        if (errors == 0 && view_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
